@@ rtl/dihedral_angle_unit_assert.svh @@
// Assertion macros for the dihedral angle unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DIHEDRAL_ANGLE_UNIT_ASSERT_SVH
`define DIHEDRAL_ANGLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DAU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dau: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define DAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dau: next-cycle check failed");
`else
`define DAU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/dau_pkg.sv @@
// Shared constants, widths, tables and transaction types of the dihedral angle unit.
// No dependencies; every RTL module of the block uses it.
`timescale 1ns / 1ps
package dau_pkg;

  localparam int COORD_BITS   = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int ROOT_FRAC    = 16;
  localparam int NORM_BITS    = 30;
  localparam int ANG_FRAC     = 16;

  // Derived widths.
  localparam int DW   = COORD_BITS + 1;      // bond vector component
  localparam int NW   = 2 * DW + 1;          // plane normal component
  localparam int SW   = 2 * DW;              // squared length of the middle bond
  localparam int RW   = DW + ROOT_FRAC;      // fixed-point bond length
  localparam int XW   = 2 * NW + 2;          // n1 . n2
  localparam int TW   = NW + DW + 2;         // n1 . b3
  localparam int VW   = XW + ROOT_FRAC;      // operands of the normalizer
  localparam int NSH  = $clog2(VW - NORM_BITS + 1);
  localparam int CXW  = NORM_BITS + 4;       // CORDIC x and y
  localparam int ZW   = ANG_FRAC + 10;       // CORDIC angle
  localparam int DEGW = 9;

  // Operand splits for the wide products.
  localparam int NH = (NW + 1) / 2;
  localparam int RH = (RW + 1) / 2;
  localparam int TH = (TW + 2) / 3;

  // Latency from the geometry stages to the bond length.
  localparam int DLY = RW - 4;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 << ANG_FRAC);

  // Cyclic neighbors for the cross product components.
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  // atan(2^-i) in degrees, scaled by 2^ANG_FRAC.
  localparam int ATAN_TAB [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_a_x;
    coord_t point_a_y;
    coord_t point_a_z;
    coord_t point_b_x;
    coord_t point_b_y;
    coord_t point_b_z;
    coord_t point_c_x;
    coord_t point_c_y;
    coord_t point_c_z;
    coord_t point_d_x;
    coord_t point_d_y;
    coord_t point_d_z;
  } point_t;

  typedef struct packed {
    logic signed [DEGW-1:0] angle_degrees;
    logic                   degenerate;
  } angle_t;

  typedef struct packed {
    logic x_neg;
    logic t_neg;
    logic degen;
  } flags_t;

  typedef struct packed {
    logic [XW-1:0] abs_x;
    logic [TW-1:0] abs_t;
    flags_t        flags;
  } geom_t;

  typedef struct packed {
    logic signed [CXW-1:0] xs;
    logic signed [CXW-1:0] ys;
    flags_t                flags;
  } norm_t;

endpackage

@@ rtl/dau_geom.sv @@
// Geometry front end: bond vectors, plane normals, dot products and their magnitudes.
// Depends on dau_pkg.
`timescale 1ns / 1ps
module dau_geom (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid,
  input  dau_pkg::point_t          point,
  output logic [dau_pkg::SW-1:0]   s_sum,
  output logic                     out_valid,
  output dau_pkg::geom_t           geom
);

  localparam int DW = dau_pkg::DW;
  localparam int NW = dau_pkg::NW;
  localparam int SW = dau_pkg::SW;
  localparam int XW = dau_pkg::XW;
  localparam int TW = dau_pkg::TW;
  localparam int NH = dau_pkg::NH;

  dau_pkg::coord_t         pt [4][3];
  logic signed [DW-1:0]    b1 [3];
  logic signed [DW-1:0]    b2 [3];
  logic signed [DW-1:0]    b3 [3];
  logic signed [DW-1:0]    b3_p2 [3];
  logic signed [DW-1:0]    b3_p3 [3];
  logic signed [2*DW-1:0]  c1 [3][2];
  logic signed [2*DW-1:0]  c2 [3][2];
  logic signed [2*DW-1:0]  sq [3];
  logic signed [NW-1:0]    n1 [3];
  logic signed [NW-1:0]    n2 [3];
  logic signed [NH:0]      n1h [3];
  logic signed [NH:0]      n1l [3];
  logic signed [NH:0]      n2h [3];
  logic signed [NH:0]      n2l [3];
  logic signed [2*NH+1:0]  xpp [3][4];
  logic signed [NH+DW:0]   tpp [3][2];
  logic signed [XW-1:0]    xprod [3];
  logic signed [TW-1:0]    tprod [3];
  logic signed [XW-1:0]    x6;
  logic signed [TW-1:0]    t6;
  logic                    degen4;
  logic                    degen5;
  logic                    degen6;
  logic [6:0]              vld;

  always_comb begin
    pt[0][0] = point.point_a_x;
    pt[0][1] = point.point_a_y;
    pt[0][2] = point.point_a_z;
    pt[1][0] = point.point_b_x;
    pt[1][1] = point.point_b_y;
    pt[1][2] = point.point_b_z;
    pt[2][0] = point.point_c_x;
    pt[2][1] = point.point_c_y;
    pt[2][2] = point.point_c_z;
    pt[3][0] = point.point_d_x;
    pt[3][1] = point.point_d_y;
    pt[3][2] = point.point_d_z;
  end

  // Normal components split into a signed high part and an unsigned low part.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n1h[j] = (NH+1)'($signed(n1[j][NW-1:NH]));
      n1l[j] = $signed({1'b0, n1[j][NH-1:0]});
      n2h[j] = (NH+1)'($signed(n2[j][NW-1:NH]));
      n2l[j] = $signed({1'b0, n2[j][NH-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Bond vectors.
      for (int j = 0; j < 3; j++) begin
        b1[j] <= DW'(pt[1][j]) - DW'(pt[0][j]);
        b2[j] <= DW'(pt[2][j]) - DW'(pt[1][j]);
        b3[j] <= DW'(pt[3][j]) - DW'(pt[2][j]);
      end
      // Cross product terms and the squared middle bond.
      for (int j = 0; j < 3; j++) begin
        c1[j][0] <= b1[dau_pkg::NXT1[j]] * b2[dau_pkg::NXT2[j]];
        c1[j][1] <= b1[dau_pkg::NXT2[j]] * b2[dau_pkg::NXT1[j]];
        c2[j][0] <= b2[dau_pkg::NXT1[j]] * b3[dau_pkg::NXT2[j]];
        c2[j][1] <= b2[dau_pkg::NXT2[j]] * b3[dau_pkg::NXT1[j]];
        sq[j]    <= b2[j] * b2[j];
        b3_p2[j] <= b3[j];
      end
      // Plane normals.
      for (int j = 0; j < 3; j++) begin
        n1[j]    <= NW'(c1[j][0]) - NW'(c1[j][1]);
        n2[j]    <= NW'(c2[j][0]) - NW'(c2[j][1]);
        b3_p3[j] <= b3_p2[j];
      end
      s_sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      // Partial products of the two dot products.
      for (int j = 0; j < 3; j++) begin
        xpp[j][0] <= n1h[j] * n2h[j];
        xpp[j][1] <= n1h[j] * n2l[j];
        xpp[j][2] <= n1l[j] * n2h[j];
        xpp[j][3] <= n1l[j] * n2l[j];
        tpp[j][0] <= n1h[j] * b3_p3[j];
        tpp[j][1] <= n1l[j] * b3_p3[j];
      end
      degen4 <= (n1[0] == '0 && n1[1] == '0 && n1[2] == '0) ||
                (n2[0] == '0 && n2[1] == '0 && n2[2] == '0);
      for (int j = 0; j < 3; j++) begin
        xprod[j] <= (XW'(xpp[j][0]) <<< (2 * NH)) +
                    ((XW'(xpp[j][1]) + XW'(xpp[j][2])) <<< NH) + XW'(xpp[j][3]);
        tprod[j] <= (TW'(tpp[j][0]) <<< NH) + TW'(tpp[j][1]);
      end
      degen5 <= degen4;
      x6     <= xprod[0] + xprod[1] + xprod[2];
      t6     <= tprod[0] + tprod[1] + tprod[2];
      degen6 <= degen5;
      geom.abs_x       <= x6[XW-1] ? XW'(-x6) : XW'(x6);
      geom.abs_t       <= t6[TW-1] ? TW'(-t6) : TW'(t6);
      geom.flags.x_neg <= x6[XW-1];
      geom.flags.t_neg <= t6[TW-1];
      geom.flags.degen <= degen6;
    end
  end

  assign out_valid = vld[6];

endmodule

@@ rtl/dau_sqrt.sv @@
// Pipelined integer square root of the scaled squared bond length, one result bit per stage.
// Depends on dau_pkg.
`timescale 1ns / 1ps
module dau_sqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [dau_pkg::SW-1:0] s_sum,
  output logic [dau_pkg::RW-1:0] root
);

  localparam int RW = dau_pkg::RW;
  localparam int RF = dau_pkg::ROOT_FRAC;

  logic [RW+1:0]   rem_q  [RW-1];
  logic [2*RW-1:0] rad_q  [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] rad_i;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic            fit;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = {s_sum, {(2 * RF){1'b0}}};
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_i, rad_i[2*RW-1 -: 2]};
    assign trial = (RW+4)'({root_i, 2'b01});
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_i[RW-2:0], fit};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= fit ? (RW+2)'(cur - trial) : (RW+2)'(cur);
          rad_q[k] <= rad_i << 2;
        end
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

@@ rtl/dau_scale.sv @@
// Forms the CORDIC operands: bond length times |n1.b3|, scaled |n1.n2|, common normalizing shift.
// Depends on dau_pkg.
`timescale 1ns / 1ps
module dau_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid,
  input  dau_pkg::geom_t         geom,
  input  logic [dau_pkg::RW-1:0] root,
  output logic                   out_valid,
  output dau_pkg::norm_t         norm
);

  localparam int XW  = dau_pkg::XW;
  localparam int VW  = dau_pkg::VW;
  localparam int RH  = dau_pkg::RH;
  localparam int TH  = dau_pkg::TH;
  localparam int NSH = dau_pkg::NSH;
  localparam int NB  = dau_pkg::NORM_BITS;
  localparam int RF  = dau_pkg::ROOT_FRAC;
  localparam int CXW = dau_pkg::CXW;
  localparam int ROWW = RH + 3 * TH;

  logic [2*RH-1:0]    rootp;
  logic [3*TH-1:0]    tabs;
  logic [RH+TH-1:0]   pp [2][3];
  logic [ROWW-1:0]    row [2];
  logic [XW-1:0]      ax1;
  logic [XW-1:0]      ax2;
  logic [VW-1:0]      y3;
  logic [VW-1:0]      a3;
  dau_pkg::flags_t    f1;
  dau_pkg::flags_t    f2;
  dau_pkg::flags_t    f3;
  logic [VW-1:0]      ny [NSH];
  logic [VW-1:0]      na [NSH];
  dau_pkg::flags_t    nf [NSH];
  logic [NSH+2:0]     vld;

  assign rootp = (2 * RH)'(root);
  assign tabs  = (3 * TH)'(geom.abs_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSH+1:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp[i][j] <= rootp[i*RH +: RH] * tabs[j*TH +: TH];
        end
      end
      ax1 <= geom.abs_x;
      f1  <= geom.flags;
      for (int i = 0; i < 2; i++) begin
        row[i] <= ROWW'(pp[i][0]) + (ROWW'(pp[i][1]) << TH) + (ROWW'(pp[i][2]) << (2 * TH));
      end
      ax2 <= ax1;
      f2  <= f1;
      y3  <= VW'(row[0]) + (VW'(row[1]) << RH);
      a3  <= {ax2, {RF{1'b0}}};
      f3  <= f2;
    end
  end

  // Binary search for the shift that brings the larger operand below 2^NB.
  for (genvar m = 0; m < NSH; m++) begin : g_norm
    localparam int K = 1 << (NSH - 1 - m);
    logic [VW-1:0]   yi;
    logic [VW-1:0]   ai;
    dau_pkg::flags_t fi;
    logic            over;

    if (m == 0) begin : g_first
      assign yi = y3;
      assign ai = a3;
      assign fi = f3;
    end else begin : g_next
      assign yi = ny[m-1];
      assign ai = na[m-1];
      assign fi = nf[m-1];
    end

    assign over = |((yi | ai) >> (NB - 1 + K));

    always_ff @(posedge clk) begin
      if (en) begin
        ny[m] <= over ? (yi >> K) : yi;
        na[m] <= over ? (ai >> K) : ai;
        nf[m] <= fi;
      end
    end
  end

  assign norm.xs    = CXW'(na[NSH-1][NB-1:0]);
  assign norm.ys    = CXW'(ny[NSH-1][NB-1:0]);
  assign norm.flags = nf[NSH-1];
  assign out_valid  = vld[NSH+2];

endmodule

@@ rtl/dau_cordic.sv @@
// CORDIC vectoring pipeline for atan2, then quadrant fold, rounding to degrees and sign.
// Depends on dau_pkg.
`timescale 1ns / 1ps
module dau_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid,
  input  dau_pkg::norm_t  norm,
  output logic            out_valid,
  output dau_pkg::angle_t angle
);

  localparam int STEPS = dau_pkg::CORDIC_STEPS;
  localparam int CXW   = dau_pkg::CXW;
  localparam int ZW    = dau_pkg::ZW;
  localparam int AF    = dau_pkg::ANG_FRAC;
  localparam int DEGW  = dau_pkg::DEGW;

  logic signed [CXW-1:0] cx [STEPS-1];
  logic signed [CXW-1:0] cy [STEPS-1];
  logic signed [ZW-1:0]  cz [STEPS];
  dau_pkg::flags_t       cf [STEPS];
  logic signed [ZW-1:0]  fold;
  logic signed [ZW-1:0]  theta;
  logic signed [ZW-1:0]  rnd;
  logic signed [ZW-1:0]  mag;
  dau_pkg::flags_t       ff;
  logic [STEPS+1:0]      vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS:0], valid};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(dau_pkg::ATAN_TAB[k]);
    logic signed [CXW-1:0] xi;
    logic signed [CXW-1:0] yi;
    logic signed [ZW-1:0]  zi;
    dau_pkg::flags_t       fi;

    if (k == 0) begin : g_first
      assign xi = norm.xs;
      assign yi = norm.ys;
      assign zi = '0;
      assign fi = norm.flags;
    end else begin : g_next
      assign xi = cx[k-1];
      assign yi = cy[k-1];
      assign zi = cz[k-1];
      assign fi = cf[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cz[k] <= yi[CXW-1] ? (zi - ANG) : (zi + ANG);
        cf[k] <= fi;
      end
    end

    if (k < STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (yi[CXW-1]) begin
            cx[k] <= xi - (yi >>> k);
            cy[k] <= yi + (xi >>> k);
          end else begin
            cx[k] <= xi + (yi >>> k);
            cy[k] <= yi - (xi >>> k);
          end
        end
      end
    end
  end

  // Obtuse angles fold around the half turn; the result is clamped to 0..180 degrees.
  assign fold = cf[STEPS-1].x_neg ? (dau_pkg::HALF_TURN - cz[STEPS-1]) : cz[STEPS-1];
  assign rnd  = theta + ZW'(1 << (AF - 1));
  assign mag  = rnd >>> AF;

  always_ff @(posedge clk) begin
    if (en) begin
      if (fold[ZW-1]) begin
        theta <= '0;
      end else if (fold > dau_pkg::HALF_TURN) begin
        theta <= dau_pkg::HALF_TURN;
      end else begin
        theta <= fold;
      end
      ff <= cf[STEPS-1];
      if (ff.degen) begin
        angle.angle_degrees <= '0;
      end else if (ff.t_neg) begin
        angle.angle_degrees <= DEGW'(-mag);
      end else begin
        angle.angle_degrees <= DEGW'(mag);
      end
      angle.degenerate <= ff.degen;
    end
  end

  assign out_valid = vld[STEPS+1];

endmodule

@@ rtl/dihedral_angle_unit.sv @@
// Top level of the dihedral angle unit: pipeline assembly, bond-length alignment, output skid.
// Depends on dau_pkg, dau_geom, dau_sqrt, dau_scale, dau_cordic and the assertion header.
//
//   channel  direction  handshake                  payload
//   point    in         point_valid / point_ready  dau_pkg::point_t (four atoms, 12 coords)
//   angle    out        angle_valid / angle_ready  dau_pkg::angle_t (degrees, degenerate)
//
// One transaction enters per clock while point_ready is high; the longest part of the latency is
// the one-bit-per-stage square root of the middle bond length.
// Reset is synchronous and clears only the valid bits and the skid flag.
// A stalled output parks its transaction in a one-entry skid register; while that register is
// full the whole pipeline holds and point_ready is low, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "dihedral_angle_unit_assert.svh"
module dihedral_angle_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  dau_pkg::point_t point,
  output logic            angle_valid,
  input  logic            angle_ready,
  output dau_pkg::angle_t angle
);

  localparam int DLY = dau_pkg::DLY;

  logic                      en;
  logic                      skid_full;
  dau_pkg::angle_t           skid_data;
  logic                      fin_valid;
  dau_pkg::angle_t           fin_data;
  logic [dau_pkg::SW-1:0]    s_sum;
  logic [dau_pkg::RW-1:0]    root;
  logic                      geom_valid;
  dau_pkg::geom_t            geom;
  dau_pkg::geom_t            dly [DLY];
  logic [DLY-1:0]            dly_vld;
  logic                      norm_valid;
  dau_pkg::norm_t            norm;

  // Every stage advances together whenever the skid register is free.
  assign en          = !skid_full;
  assign point_ready = en;

  dau_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (point_valid),
    .point     (point),
    .s_sum     (s_sum),
    .out_valid (geom_valid),
    .geom      (geom)
  );

  // The bond length runs in parallel with the dot products.
  dau_sqrt u_sqrt (
    .clk   (clk),
    .en    (en),
    .s_sum (s_sum),
    .root  (root)
  );

  // Delay the dot product results until the matching bond length leaves the root pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
    end else if (en) begin
      dly_vld <= {dly_vld[DLY-2:0], geom_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= geom;
      for (int i = 1; i < DLY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  dau_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (dly_vld[DLY-1]),
    .geom      (dly[DLY-1]),
    .root      (root),
    .out_valid (norm_valid),
    .norm      (norm)
  );

  dau_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (norm_valid),
    .norm      (norm),
    .out_valid (fin_valid),
    .angle     (fin_data)
  );

  // The skid register catches the last stage when the consumer stalls, so the final
  // stage can still advance in that cycle. It always holds the older transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (angle_ready) begin
        skid_full <= 1'b0;
      end
    end else if (fin_valid && !angle_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && fin_valid && !angle_ready) begin
      skid_data <= fin_data;
    end
  end

  assign angle_valid = skid_full || fin_valid;
  assign angle       = skid_full ? skid_data : fin_data;

  `DAU_ASSERT_NEXT(a_skid_hold, clk, rst, skid_full && !angle_ready, skid_full && $stable(skid_data))
  `DAU_ASSERT_IMPLY(a_skid_load, clk, rst, $rose(skid_full), $past(fin_valid) && !$past(angle_ready))
  `DAU_ASSERT_IMPLY(a_degen_zero, clk, rst, angle_valid && angle.degenerate, angle.angle_degrees == '0)
  `DAU_ASSERT_IMPLY(a_range, clk, rst, angle_valid, (angle.angle_degrees >= -180) && (angle.angle_degrees <= 180))

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for dihedral_angle_unit: random and directed atom quadruples.
// Depends on dau_pkg and the RTL of the block; holds its own torsion predictor.
`timescale 1ns / 1ps
module tb_top;

  typedef logic signed [255:0] wide_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            point_valid = 1'b0;
  logic            point_ready;
  dau_pkg::point_t point = '0;
  logic            angle_valid;
  logic            angle_ready = 1'b0;
  dau_pkg::angle_t angle;

  // Transactions still to be driven, and angles predicted but not yet observed.
  dau_pkg::point_t pending_points[$];
  dau_pkg::angle_t expected_angles[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_run = 0;
  logic stall_now = 1'b0;

  dihedral_angle_unit dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle       (angle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int bit_length(wide_t v);
    for (int i = 255; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic wide_t floor_root(wide_t n);
    wide_t r;
    wide_t c;
    r = '0;
    for (int b = 51; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Bit-exact torsion predictor: exact integer geometry, normalization, CORDIC vectoring.
  function automatic dau_pkg::angle_t predict_torsion(dau_pkg::point_t p);
    wide_t  pt[4][3];
    wide_t  b1[3], b2[3], b3[3], n1[3], n2[3];
    wide_t  dot_nn, dot_nb, len_sq, root, mag_y, mag_x;
    longint xs, ys, z, dx, dy, theta, deg;
    int     len, sh;
    dau_pkg::angle_t res;
    pt[0][0] = wide_t'(p.point_a_x); pt[0][1] = wide_t'(p.point_a_y);
    pt[0][2] = wide_t'(p.point_a_z);
    pt[1][0] = wide_t'(p.point_b_x); pt[1][1] = wide_t'(p.point_b_y);
    pt[1][2] = wide_t'(p.point_b_z);
    pt[2][0] = wide_t'(p.point_c_x); pt[2][1] = wide_t'(p.point_c_y);
    pt[2][2] = wide_t'(p.point_c_z);
    pt[3][0] = wide_t'(p.point_d_x); pt[3][1] = wide_t'(p.point_d_y);
    pt[3][2] = wide_t'(p.point_d_z);
    for (int j = 0; j < 3; j++) begin
      b1[j] = pt[1][j] - pt[0][j];
      b2[j] = pt[2][j] - pt[1][j];
      b3[j] = pt[3][j] - pt[2][j];
    end
    for (int j = 0; j < 3; j++) begin
      n1[j] = b1[(j+1)%3] * b2[(j+2)%3] - b1[(j+2)%3] * b2[(j+1)%3];
      n2[j] = b2[(j+1)%3] * b3[(j+2)%3] - b2[(j+2)%3] * b3[(j+1)%3];
    end
    res = '0;
    if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
        (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
      res.degenerate = 1'b1;
      return res;
    end
    dot_nn = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
    dot_nb = n1[0] * b3[0] + n1[1] * b3[1] + n1[2] * b3[2];
    len_sq = b2[0] * b2[0] + b2[1] * b2[1] + b2[2] * b2[2];
    root = floor_root(len_sq << (2 * dau_pkg::ROOT_FRAC));
    mag_y = root * (dot_nb < 0 ? -dot_nb : dot_nb);
    mag_x = (dot_nn < 0 ? -dot_nn : dot_nn) << dau_pkg::ROOT_FRAC;
    len = bit_length(mag_y);
    if (bit_length(mag_x) > len) len = bit_length(mag_x);
    sh = len > dau_pkg::NORM_BITS ? len - dau_pkg::NORM_BITS : 0;
    mag_y = mag_y >> sh;
    mag_x = mag_x >> sh;
    xs = longint'({32'b0, mag_x[31:0]});
    ys = longint'({32'b0, mag_y[31:0]});
    z = 0;
    for (int k = 0; k < dau_pkg::CORDIC_STEPS && k < 32; k++) begin
      dx = ys >>> k;
      dy = xs >>> k;
      if (ys < 0) begin
        xs -= dx; ys += dy; z -= dau_pkg::ATAN_TAB[k];
      end else begin
        xs += dx; ys -= dy; z += dau_pkg::ATAN_TAB[k];
      end
    end
    theta = (dot_nn < 0) ? (longint'(180) <<< dau_pkg::ANG_FRAC) - z : z;
    if (theta < 0) theta = 0;
    if (theta > (longint'(180) <<< dau_pkg::ANG_FRAC)) begin
      theta = longint'(180) <<< dau_pkg::ANG_FRAC;
    end
    deg = (theta + (longint'(1) <<< (dau_pkg::ANG_FRAC - 1))) >>> dau_pkg::ANG_FRAC;
    if (dot_nb < 0) deg = -deg;
    res.angle_degrees = deg[dau_pkg::DEGW-1:0];
    return res;
  endfunction

  function automatic dau_pkg::point_t make_quad(int ax, int ay, int az,
                                                int bx, int by, int bz,
                                                int cx, int cy, int cz,
                                                int dx, int dy, int dz);
    dau_pkg::point_t p;
    p.point_a_x = dau_pkg::coord_t'(ax); p.point_a_y = dau_pkg::coord_t'(ay);
    p.point_a_z = dau_pkg::coord_t'(az);
    p.point_b_x = dau_pkg::coord_t'(bx); p.point_b_y = dau_pkg::coord_t'(by);
    p.point_b_z = dau_pkg::coord_t'(bz);
    p.point_c_x = dau_pkg::coord_t'(cx); p.point_c_y = dau_pkg::coord_t'(cy);
    p.point_c_z = dau_pkg::coord_t'(cz);
    p.point_d_x = dau_pkg::coord_t'(dx); p.point_d_y = dau_pkg::coord_t'(dy);
    p.point_d_z = dau_pkg::coord_t'(dz);
    return p;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic report_mismatch(string what, dau_pkg::angle_t got, dau_pkg::angle_t want);
    $display("mismatch %s: got angle %0d degenerate %0b, want angle %0d degenerate %0b",
             what, got.angle_degrees, got.degenerate, want.angle_degrees, want.degenerate);
    error_count++;
  endtask

  // Driver: a transaction leaves the queue only when the previous one has been taken,
  // and the prediction is made at the edge where the block accepts it.
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_ready) begin
      if (point_valid) expected_angles.push_back(predict_torsion(point));
      if (gap_left > 0) begin
        gap_left--;
        point_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point_valid <= 1'b1;
        point <= pending_points.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternates runs of ready and stalls; the first stretch after reset never stalls.
  always @(posedge clk) begin
    if (rst) begin
      angle_ready <= 1'b0;
      stall_run = 300;
      stall_now = 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_now = ($urandom_range(2) == 0);
        stall_run = stall_now ? $urandom_range(1, 25) : $urandom_range(1, 60);
      end
      stall_run--;
      angle_ready <= !stall_now;
    end
  end

  // Monitor: every accepted angle is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && angle_valid && angle_ready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected transaction", angle, '0);
      end else begin
        if (angle.angle_degrees !== expected_angles[0].angle_degrees)
          report_mismatch("angle_degrees", angle, expected_angles[0]);
        if (angle.degenerate !== expected_angles[0].degenerate)
          report_mismatch("degenerate", angle, expected_angles[0]);
        void'(expected_angles.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dihedral_angle_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int              mode;
    int              px, py, pz;
    int              c[12];
    dau_pkg::point_t q;

    // Directed part: degenerate layouts, the planar and right-angle torsions, extremes.
    pending_points.push_back(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_points.push_back(make_quad(0, 0, 0, 1024, 0, 0, 2048, 0, 0, 0, 1024, 0));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 3072, 0, 0));
    pending_points.push_back(make_quad(0, 1024, 0, 500, 0, 0, 500, 0, 0, 0, 9, 7));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, -1024, 0));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 1024, 0));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 0, 1024));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 0, -1024));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 887, 512));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, -512, -887));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, 1, -1));
    pending_points.push_back(make_quad(0, 1024, 0, 0, 0, 0, 1024, 0, 0, 1024, -1, 1));
    pending_points.push_back(make_quad(524287, 524287, 524287, 524287, 524287, 524287,
                                       524287, 524287, 524287, 524287, 524287, 524287));
    pending_points.push_back(make_quad(-524288, -524288, -524288, 524287, -524288, 524287,
                                       524287, 524287, -524288, -524288, 524287, 524287));
    pending_points.push_back(make_quad(524287, 524287, 524287, -524288, 524287, -524288,
                                       -524288, -524288, 524287, 524287, -524288, -524288));
    pending_points.push_back(make_quad(-524288, 0, 0, 0, 0, 0, 0, 524287, 0, 0, 524287, 524287));
    pending_points.push_back(make_quad(524287, -524288, 0, -524288, 524287, 0,
                                       524287, 524287, 0, -524288, -524288, 0));
    pending_points.push_back(make_quad(-524288, -524288, -524288, 1, 0, 0, 0, 1, 0, 0, 0, 1));

    // Random part: mostly chain-like geometry, with raw noise, collinear and planar layouts.
    for (int n = 0; n < 450; n++) begin
      mode = $urandom_range(99);
      if (mode < 65) begin
        px = jitter(130000); py = jitter(130000); pz = jitter(130000);
        for (int k = 0; k < 4; k++) begin
          c[3*k] = px; c[3*k+1] = py; c[3*k+2] = pz;
          px += jitter(3000); py += jitter(3000); pz += jitter(3000);
        end
      end else if (mode < 82) begin
        for (int k = 0; k < 12; k++) c[k] = $signed(20'($urandom));
      end else if (mode < 92) begin
        px = jitter(2000); py = jitter(2000); pz = jitter(2000);
        for (int k = 0; k < 12; k++) c[k] = jitter(5000);
        for (int k = 0; k < 3; k++) begin
          c[3*k] = c[0] + k * px; c[3*k+1] = c[1] + k * py; c[3*k+2] = c[2] + k * pz;
        end
        if ($urandom_range(1)) begin
          for (int k = 0; k < 3; k++) c[3+k] = c[6+k];
        end
      end else begin
        for (int k = 0; k < 12; k++) c[k] = (k % 3 == 2) ? 0 : jitter(4000);
      end
      q = make_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]);
      pending_points.push_back(q);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_points.size() != 0 || point_valid || expected_angles.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("dihedral_angle_unit regression: pass");
    end else begin
      $display("dihedral_angle_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dau_pkg.sv
rtl/dau_geom.sv
rtl/dau_sqrt.sv
rtl/dau_scale.sv
rtl/dau_cordic.sv
rtl/dihedral_angle_unit.sv
dv/tb_top.sv
